@@ hdl/rmpw_pkg.sv @@
// Shared types and constants for the rotated mono pixel writer.
// No dependencies; imported by rmpw_dp, rmpw_ctrl and the top level.
`default_nettype none

package rmpw_pkg;

    // default buffer size limits (top-level parameter defaults)
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // signed working width for coordinates and bounds (12-bit field + 1)
    localparam int CW = 13;

    // field widths
    localparam int KIND_W  = 2;
    localparam int POS_W   = 12;
    localparam int ADDR_W  = 13;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int BYTE_W  = 8;
    localparam logic [BYTE_W-1:0] LEFT_BIT = 8'h80;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 2'd3;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ROT   = 2'd0,
        KIND_ABS   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    // controller -> datapath commands
    typedef struct packed {
        logic latch_in;   // capture the input beat
        logic map_en;     // register mapped coordinates and range check
        logic ram_rd;     // issue the byte read
        logic rmw_en;     // write back the modified byte
        logic clr_en;     // write one fill byte, advance sweep counter
        logic load_out;   // load the result register
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        t_kind kind;
        logic  clr_last;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hdl/rmpw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module rmpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire                                    i_clk,
    input  wire                                    i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                        i_wdata,
    input  wire                                    i_re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/rmpw_dp.sv @@
// Datapath: config registers, coordinate mapping, byte address, pixel RAM,
// read-modify-write and result register. Depends on rmpw_pkg and rmpw_ram.
`default_nettype none

module rmpw_dp import rmpw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // configuration
    input  wire                        i_cfg_we,
    input  wire [CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [CFG_W-1:0]            i_cfg_data,
    // item fields
    input  wire [KIND_W-1:0]           i_kind,
    input  wire signed [POS_W-1:0]     i_pos_x,
    input  wire signed [POS_W-1:0]     i_pos_y,
    input  wire                        i_colored,
    input  wire [ADDR_W-1:0]           i_byte_addr,
    // control
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    // result
    output logic                       o_written,
    output logic [BYTE_W-1:0]          o_read_data
);

    localparam int DEPTH = (MAX_WIDTH / 8) * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // one spare bit keeps the byte-column slice nonempty at the smallest width
    localparam int XW    = $clog2(MAX_WIDTH) + 1;
    localparam int YW    = $clog2(MAX_HEIGHT) + 1;
    localparam int RBW   = $clog2(MAX_WIDTH / 8 + 1);
    localparam logic signed [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
    localparam logic signed [CW-1:0] MAXH_C = CW'(MAX_HEIGHT);
    localparam logic signed [CW-1:0] ONE_C  = CW'(1);
    localparam logic [AW-1:0]        LAST_C = AW'(DEPTH - 1);

    // configuration registers
    logic [CFG_W-1:0] r_line_width;
    logic [CFG_W-1:0] r_line_count;
    logic [1:0]       r_rotation;
    logic             r_invert;

    // latched item
    t_kind                  r_kind;
    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;
    logic                   r_colored;
    logic [ADDR_W-1:0]      r_addr;

    // mapped pixel
    logic                   r_ok;
    logic [XW-1:0]          r_px;
    logic [YW-1:0]          r_py;
    logic [RBW-1:0]         r_rb;

    logic [AW-1:0]          r_cnt;

    // ram
    logic [BYTE_W-1:0]      ram_q;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [BYTE_W-1:0]      ram_wdata;

    // mapping logic
    logic signed [CW-1:0]   lw_c, lh_c, w_c, w8_c, h_c, x_c, y_c, bx_c, by_c, px_c, py_c;
    logic                   swap_c, in_rng_c, ok_c;
    logic [1:0]             rot_c;
    logic [YW+RBW-1:0]      prod_c;
    logic [AW-1:0]          idx_c;
    logic [BYTE_W-1:0]      mask_c, mod_c;
    logic                   bitv_c, draw_c;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= CFG_W'(256);
            r_line_count <= CFG_W'(256);
            r_rotation   <= 2'd0;
            r_invert     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                CFG_LINE_COUNT: r_line_count <= i_cfg_data;
                CFG_ROTATION:   r_rotation   <= i_cfg_data[1:0];
                CFG_INVERT:     r_invert     <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // effective width (clamped, whole bytes) and height (clamped)
    assign lw_c = $signed(CW'(r_line_width));
    assign lh_c = $signed(CW'(r_line_count));
    assign w_c  = (lw_c > MAXW_C) ? MAXW_C : lw_c;
    assign w8_c = {w_c[CW-1:3], 3'b000};
    assign h_c  = (lh_c > MAXH_C) ? MAXH_C : lh_c;

    assign x_c = CW'(r_x);
    assign y_c = CW'(r_y);

    // absolute draws use the unrotated mapping
    assign rot_c  = (r_kind == KIND_ROT) ? r_rotation : 2'd0;
    assign swap_c = rot_c[0];
    assign bx_c   = swap_c ? h_c : w8_c;
    assign by_c   = swap_c ? w8_c : h_c;
    assign in_rng_c = !x_c[CW-1] && !y_c[CW-1] && (x_c < bx_c) && (y_c < by_c);

    always_comb begin
        unique case (rot_c)
            2'd0: begin px_c = x_c;                py_c = y_c;                end
            2'd1: begin px_c = w8_c - ONE_C - y_c; py_c = x_c;                end
            2'd2: begin px_c = w8_c - ONE_C - x_c; py_c = h_c - ONE_C - y_c; end
            default: begin px_c = y_c;             py_c = h_c - ONE_C - x_c; end
        endcase
    end

    always_comb begin
        unique case (r_kind)
            KIND_ROT, KIND_ABS: ok_c = in_rng_c;
            KIND_CLEAR:         ok_c = 1'b1;
            default:            ok_c = (32'(r_addr) < 32'(DEPTH));
        endcase
    end

    // item latch and mapping registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_kind    <= t_kind'(i_kind);
            r_x       <= i_pos_x;
            r_y       <= i_pos_y;
            r_colored <= i_colored;
            r_addr    <= i_byte_addr;
        end
        if (i_cmd.map_en) begin
            r_ok <= ok_c;
            r_px <= px_c[XW-1:0];
            r_py <= py_c[YW-1:0];
            r_rb <= w8_c[RBW+2:3];
        end
    end

    // byte index: row * bytes-per-row + column / 8; a read uses its given byte address
    assign prod_c = r_py * r_rb;
    assign idx_c  = (r_kind == KIND_READ) ? AW'(r_addr)
                                          : AW'(prod_c) + AW'(r_px[XW-1:3]);

    // read-modify-write byte
    assign draw_c = (r_kind == KIND_ROT) || (r_kind == KIND_ABS);
    assign bitv_c = (r_colored == r_invert);
    assign mask_c = LEFT_BIT >> r_px[2:0];
    assign mod_c  = bitv_c ? (ram_q | mask_c) : (ram_q & ~mask_c);

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.map_en) begin
            r_cnt <= '0;
        end else if (i_cmd.clr_en) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    assign ram_we    = (i_cmd.rmw_en && r_ok && draw_c) || i_cmd.clr_en;
    assign ram_waddr = i_cmd.clr_en ? r_cnt : idx_c;
    assign ram_wdata = i_cmd.clr_en ? {BYTE_W{bitv_c}} : mod_c;

    rmpw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (idx_c),
        .o_rdata (ram_q)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_written   <= (r_kind == KIND_CLEAR) || (draw_c && r_ok);
            o_read_data <= ((r_kind == KIND_READ) && r_ok) ? ram_q : '0;
        end
    end

    assign o_sts.kind     = r_kind;
    assign o_sts.clr_last = (r_cnt == LAST_C);

endmodule

`default_nettype wire

@@ hdl/rmpw_ctrl.sv @@
// Controller FSM: sequences map, read, modify-write, clear sweep and result.
// Depends on rmpw_pkg.
`default_nettype none

module rmpw_ctrl import rmpw_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  wire      i_m_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_RD,
        ST_RMW,
        ST_CLR,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_m_tvalid, n_m_tvalid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.latch_in = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                o_cmd.map_en = 1'b1;
                n_state = (i_sts.kind == KIND_CLEAR) ? ST_CLR : ST_RD;
            end
            ST_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state = ST_RMW;
            end
            ST_RMW: begin
                o_cmd.rmw_en = 1'b1;
                n_state = ST_DONE;
            end
            ST_CLR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // output register free or draining this cycle
                if (!r_m_tvalid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_m_tvalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;

endmodule

`default_nettype wire

@@ hdl/rotated_mono_pixel_writer.sv @@
// A draw or read beat is mapped after acceptance, then its byte read, modified
// and written back and its result loaded; a clear writes every store byte in
// turn, one store byte written per cycle. A new beat is taken only after the
// last result is loaded, as the single RAM port pair does read-modify-write
// for one item at a time. Reset (synchronous, active low) clears control and
// config; the store contents stay undefined until a clear beat.
// Top level; depends on rmpw_pkg, rmpw_ctrl, rmpw_dp.
`default_nettype none

module rotated_mono_pixel_writer import rmpw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input stream
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    input  wire [39:0]           i_s_tdata,  // pos_x[11:0], pos_y[23:12], colored[24],
                                             // byte_addr[37:25], zero pad[39:38]
    input  wire [KIND_W-1:0]     i_s_tuser,  // kind[1:0]
    // result stream
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    output logic [15:0]          o_m_tdata,  // written[0], read_data[8:1], zero pad[15:9]
    // configuration
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data
);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic              written;
    logic [BYTE_W-1:0] read_data;

    rmpw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rmpw_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (i_s_tuser),
        .i_pos_x     (i_s_tdata[11:0]),
        .i_pos_y     (i_s_tdata[23:12]),
        .i_colored   (i_s_tdata[24]),
        .i_byte_addr (i_s_tdata[37:25]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_written   (written),
        .o_read_data (read_data)
    );

    assign o_m_tdata = {7'd0, read_data, written};

    // one item at a time: input closes right after a beat is taken
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item is in flight");

    // a result with nonzero read data never reports a store
    a_read_not_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[8:1] != 8'd0)) |-> !o_m_tdata[0])
        else $error("nonzero read data with written flag set");

    // a new result appears only after the item left the input side
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result loaded while idle");

    // padding bits of the result beat stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:9] == 7'd0))
        else $error("result padding not zero");

endmodule

`default_nettype wire
